// File: sv/ptw_pkg.sv
// Shared types, codes and constants of the page table walker.
`timescale 1ns / 1ps

package ptw_pkg;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAULT = 2'd2,
        KIND_DROP  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PAGE_4K = 2'd0,
        PAGE_2M = 2'd1,
        PAGE_1G = 2'd2
    } page_size_t;

    localparam int unsigned ADDR_W      = 48;
    localparam int unsigned DATA_W      = 64;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] LEVEL_TOP = 2'd3;
    localparam logic [1:0] LEVEL_1G  = 2'd2;
    localparam logic [1:0] LEVEL_2M  = 2'd1;
    localparam logic [1:0] LEVEL_4K  = 2'd0;

    localparam int unsigned PRESENT_POS = 0;
    localparam int unsigned LARGE_BIT   = 7;

    // Classified item as it waits between the front and the back.
    typedef struct packed {
        logic              is_data;
        logic              present;
        logic              size_flag;
        logic [ADDR_W-1:0] addr;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } head_t;

    // Frame bits 12 up to phys_bits-1 of an entry or of the root.
    function automatic logic [DATA_W-1:0] frame_mask(input int unsigned phys_bits);
        logic [DATA_W-1:0] mask;
        mask = ((64'd1 << phys_bits) - 64'd1) & ~64'hFFF;
        return mask;
    endfunction

endpackage

// File: sv/ptw_ifs.sv
// Channel interfaces of the page table walker.
`timescale 1ns / 1ps

interface ptw_item_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [ptw_pkg::ADDR_W-1:0]  virt_addr;
    logic [ptw_pkg::DATA_W-1:0]  read_data;

    modport source (output valid, output req_type, output virt_addr, output read_data,
                    input ready);
    modport sink (input valid, input req_type, input virt_addr, input read_data,
                  output ready);
endinterface

interface ptw_result_if;
    logic                        valid;
    logic                        ready;
    ptw_pkg::kind_t              kind;
    logic [ptw_pkg::ADDR_W-1:0]  address;
    ptw_pkg::page_size_t         page_size;

    modport source (output valid, output kind, output address, output page_size,
                    input ready);
    modport sink (input valid, input kind, input address, input page_size,
                  output ready);
endinterface

interface ptw_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [ptw_pkg::ADDR_W-1:0]  table_root;

    modport source (output valid, output table_root, input ready);
    modport sink (input valid, input table_root, output ready);
endinterface

// File: sv/ptw_front.sv
// Front of the walker: classifies incoming items and queues them for the back.
`timescale 1ns / 1ps

module ptw_front #(
    parameter int unsigned PHYS_ADDR_BITS = 48
) (
    input  logic            clk,
    input  logic            rst_n,
    ptw_item_if.sink        item,
    input  logic            pop,
    output ptw_pkg::head_t  head
);
    import ptw_pkg::*;

    localparam logic [DATA_W-1:0] FRAME_MASK = frame_mask(PHYS_ADDR_BITS);

    entry_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [DATA_W-1:0]   entry_frame;
    entry_t              incoming;
    logic                push;

    assign item.ready = (count_reg != COUNT_W'(QUEUE_DEPTH));
    assign push       = item.valid && item.ready;

    // Read data carries its frame in the address field, a translate its virtual address.
    always_comb
    begin
        entry_frame        = item.read_data & FRAME_MASK;
        incoming.is_data   = item.req_type;
        incoming.present   = item.read_data[PRESENT_POS];
        incoming.size_flag = item.read_data[LARGE_BIT];
        incoming.addr      = item.req_type ? entry_frame[ADDR_W-1:0] : item.virt_addr;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= incoming;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = queue_reg[rd_ptr_reg];

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds its depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a transfer in");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not follow a pop");
`endif

endmodule

// File: sv/ptw_back.sv
// Back of the walker: holds the walk state and forms one result per queued item.
`timescale 1ns / 1ps

module ptw_back #(
    parameter int unsigned PHYS_ADDR_BITS = 48
) (
    input  logic            clk,
    input  logic            rst_n,
    ptw_cfg_if.sink         cfg,
    input  ptw_pkg::head_t  head,
    output logic            pop,
    ptw_result_if.source    result
);
    import ptw_pkg::*;

    localparam logic [DATA_W-1:0] FRAME_MASK = frame_mask(PHYS_ADDR_BITS);

    logic [ADDR_W-1:0]  root_reg;
    logic               active_reg;
    logic               active_next;
    logic [1:0]         level_reg;
    logic [1:0]         level_next;
    logic [ADDR_W-1:0]  vaddr_reg;
    logic [ADDR_W-1:0]  vaddr_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    kind_t              kind_reg;
    logic [ADDR_W-1:0]  address_reg;
    page_size_t         page_size_reg;
    kind_t              res_kind;
    logic [ADDR_W-1:0]  res_addr;
    page_size_t         res_size;
    logic [8:0]         next_index;
    entry_t             e;

    assign cfg.ready = 1'b1;
    assign e         = head.entry;
    assign pop       = head.valid && (!out_valid_reg || result.ready);

    always_comb
    begin
        case (level_reg)
            LEVEL_TOP: next_index = vaddr_reg[38:30];
            LEVEL_1G:  next_index = vaddr_reg[29:21];
            default:   next_index = vaddr_reg[20:12];
        endcase
    end

    always_comb
    begin
        res_kind    = KIND_DROP;
        res_addr    = '0;
        res_size    = PAGE_4K;
        active_next = active_reg;
        level_next  = level_reg;
        vaddr_next  = vaddr_reg;
        if (pop)
        begin
            if (!e.is_data)
            begin
                if (!active_reg)
                begin
                    vaddr_next  = e.addr;
                    active_next = 1'b1;
                    level_next  = LEVEL_TOP;
                    res_kind    = KIND_READ;
                    res_addr    = root_reg | {36'd0, e.addr[47:39], 3'd0};
                end
            end
            else if (active_reg)
            begin
                if (!e.present)
                begin
                    res_kind    = KIND_FAULT;
                    active_next = 1'b0;
                    level_next  = LEVEL_4K;
                end
                else if (level_reg == LEVEL_1G && e.size_flag)
                begin
                    res_kind    = KIND_DONE;
                    res_addr    = {e.addr[47:30], vaddr_reg[29:0]};
                    res_size    = PAGE_1G;
                    active_next = 1'b0;
                    level_next  = LEVEL_4K;
                end
                else if (level_reg == LEVEL_2M && e.size_flag)
                begin
                    res_kind    = KIND_DONE;
                    res_addr    = {e.addr[47:21], vaddr_reg[20:0]};
                    res_size    = PAGE_2M;
                    active_next = 1'b0;
                    level_next  = LEVEL_4K;
                end
                else if (level_reg == LEVEL_4K)
                begin
                    res_kind    = KIND_DONE;
                    res_addr    = {e.addr[47:12], vaddr_reg[11:0]};
                    active_next = 1'b0;
                end
                else
                begin
                    res_kind   = KIND_READ;
                    res_addr   = e.addr | {36'd0, next_index, 3'd0};
                    level_next = level_reg - 2'd1;
                end
            end
        end
    end

    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg      <= '0;
            active_reg    <= 1'b0;
            level_reg     <= LEVEL_4K;
            vaddr_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                root_reg <= cfg.table_root & FRAME_MASK[ADDR_W-1:0];
            end
            active_reg    <= active_next;
            level_reg     <= level_next;
            vaddr_reg     <= vaddr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg      <= res_kind;
            address_reg   <= res_addr;
            page_size_reg <= res_size;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.kind      = kind_reg;
    assign result.address   = address_reg;
    assign result.page_size = page_size_reg;

`ifndef SYNTH
    a_end_clears_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (res_kind == KIND_DONE || res_kind == KIND_FAULT)) |=> !active_reg)
        else $error("walk still active after it ended");

    a_read_keeps_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && res_kind == KIND_READ) |=> active_reg)
        else $error("read request issued without an active walk");

    a_size_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && page_size_reg != PAGE_4K) |-> kind_reg == KIND_DONE)
        else $error("page size given on a result that is not a translation");

    a_drop_no_state: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && res_kind == KIND_DROP) |=> active_reg == $past(active_reg)
            && level_reg == $past(level_reg))
        else $error("dropped item changed the walk state");
`endif

endmodule

// File: sv/four_level_page_table_walker.sv
// Four-level page table walker with a large-page aware 48-bit translation.
//
// Channels: item takes translate requests (req_type 0, virt_addr) and table
// entries returned from memory (req_type 1, read_data); result gives one item
// per input item: a memory read request, a finished translation, a fault, or a
// report that an item arrived out of turn and was dropped. cfg writes the
// table root, taken at a transfer; the user must transfer only while the block
// is idle, as the block itself does not enforce this. An item taken is written
// into the queue, then popped by the back end into the result register, which
// holds its result valid. Throughput: one item per cycle while the receiver
// takes results, set by the back end walk step, popping one queued item per cycle.
// A two-entry queue sits between the classifying front end and the back end.
// When the receiver stalls, the result register holds its item, the queue
// fills, and item.ready falls once both queue entries are taken.
// Reset clears the root to zero, ends any walk and empties the queue and the
// result register.
`timescale 1ns / 1ps

module four_level_page_table_walker #(
    parameter int unsigned PHYS_ADDR_BITS = 48
) (
    input  logic          clk,
    input  logic          rst_n,
    ptw_cfg_if.sink       cfg,
    ptw_item_if.sink      item,
    ptw_result_if.source  result
);
    import ptw_pkg::*;

    head_t  head;
    logic   pop;

    ptw_front #(
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .pop   (pop),
        .head  (head)
    );

    ptw_back #(
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule
